// File: design/srarq_pkg.sv
`default_nettype none
package srarq_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RX   = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_CHUNK = 2'd2;
  localparam logic [1:0] KIND_FULL  = 2'd3;

  // ack packets carry a fixed body
  localparam logic [63:0] ACK_DATA  = 64'h0101010101010101;
  localparam logic [15:0] ACK_CHECK = 16'hfbfb;

  // register index of timeout_ticks (paddr bit 2)
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3;

  // widest slot number the queue entry carries
  localparam int SLOT_W_MAX = 8;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] payload;
    logic        end_mark;
    logic [15:0] rx_seq;
    logic        rx_is_ack;
    logic [15:0] rx_check;
  } item_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [15:0] check;
    logic [63:0] data;
    logic        msg_end;
    logic        last;
  } result_t;

  // classified item between front and back
  typedef struct packed {
    logic [1:0]            op;
    logic [63:0]           payload;
    logic                  end_mark;
    logic [15:0]           rx_seq;
    logic                  rx_is_ack;
    logic [15:0]           csum;
    logic                  csum_ok;
    logic [SLOT_W_MAX-1:0] rx_slot;
  } qent_t;

  // ones-complement checksum over four little-endian words
  function automatic logic [15:0] csum(input logic [63:0] p);
    logic [17:0] s;
    logic [16:0] f1;
    logic [16:0] f2;
    s  = 18'(p[15:0]) + 18'(p[31:16]) + 18'(p[47:32]) + 18'(p[63:48]);
    f1 = 17'(s[15:0]) + 17'(s[17:16]);
    f2 = 17'(f1[15:0]) + 17'(f1[16]);
    return ~f2[15:0];
  endfunction

endpackage
`default_nettype wire

// File: design/srarq_ram.sv
`default_nettype none
module srarq_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/srarq_front.sv
`default_nettype none
module srarq_front #(
  parameter int WINDOW = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire srarq_pkg::item_in_t in_item,
  output logic                     push,
  output srarq_pkg::qent_t         push_ent,
  input  wire logic                q_full
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / WINDOW);
  localparam logic [16:0] WIN17 = 17'(WINDOW);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t             state;
  srarq_pkg::item_in_t item;
  logic [15:0]         csum_r;
  logic [47:0]         prod;

  logic [15:0] quot;
  logic [16:0] rem;
  logic [16:0] slot;

  // slot = rx_seq mod WINDOW via reciprocal, one correction step
  always_comb begin
    quot = prod[47:32];
    rem  = {1'b0, item.rx_seq} - 17'(32'(quot) * 32'(WINDOW));
    slot = (rem >= WIN17) ? (rem - WIN17) : rem;
  end

  assign in_stall = (state != F_IDLE);
  assign push     = (state == F_PUSH) && !q_full;

  always_comb begin
    push_ent.op        = item.op;
    push_ent.payload   = item.payload;
    push_ent.end_mark  = item.end_mark;
    push_ent.rx_seq    = item.rx_seq;
    push_ent.rx_is_ack = item.rx_is_ack;
    push_ent.csum      = csum_r;
    push_ent.csum_ok   = (csum_r == item.rx_check);
    push_ent.rx_slot   = slot[srarq_pkg::SLOT_W_MAX-1:0];
  end

  // accept, compute checksum and quotient, hand over to the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            state <= F_CALC;
          end
        end
        F_CALC: begin
          csum_r <= srarq_pkg::csum(item.payload);
          prod   <= 48'(item.rx_seq) * 48'(RECIP);
          state  <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/srarq_queue.sv
`default_nettype none
module srarq_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire srarq_pkg::qent_t push_ent,
  output logic                  full,
  input  wire logic             pop,
  output srarq_pkg::qent_t      head,
  output logic                  not_empty
);

  srarq_pkg::qent_t ent [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = ent[rd_ptr];

  // two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_ent;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/srarq_back.sv
`default_nettype none
module srarq_back #(
  parameter int WINDOW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [15:0]      timeout_ticks,
  input  wire srarq_pkg::qent_t head,
  input  wire logic             not_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output srarq_pkg::result_t    out_item
);

  localparam int SW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);
  localparam logic [15:0]   WIN16     = 16'(WINDOW);
  localparam logic [CW-1:0] WINC      = CW'(WINDOW);

  typedef enum logic [10:0] {
    B_IDLE     = 11'b00000000001,
    B_DISPATCH = 11'b00000000010,
    B_SEND     = 11'b00000000100,
    B_RXD      = 11'b00000001000,
    B_RXOLD    = 11'b00000010000,
    B_DLV_CHK  = 11'b00000100000,
    B_DLV_EMIT = 11'b00001000000,
    B_SLIDE    = 11'b00010000000,
    B_TICK_RD  = 11'b00100000000,
    B_TICK_EV  = 11'b01000000000,
    B_FLUSH    = 11'b10000000000
  } bstate_t;

  bstate_t          state;
  srarq_pkg::qent_t cur;
  logic [15:0]      tx_base;
  logic [15:0]      next_send_seq;
  logic [15:0]      rx_base;
  logic [15:0]      tick_count;
  logic [SW-1:0]    sb_slot;
  logic [SW-1:0]    ns_slot;
  logic [SW-1:0]    rb_slot;
  logic [WINDOW-1:0] flag_out;
  logic [WINDOW-1:0] flag_ack;
  logic [WINDOW-1:0] recv_valid;
  logic [15:0]      scan_q;
  logic [SW-1:0]    scan_slot;
  logic [CW-1:0]    remain;
  logic [CW-1:0]    dcount;
  srarq_pkg::result_t pend;
  logic             pend_valid;

  // memory ports
  logic          st_we, st_re, tm_we, tm_re, rv_we, rv_re;
  logic [SW-1:0] st_waddr, tm_waddr, rv_waddr, rv_raddr;
  logic [64:0]   st_rdata, rv_rdata;
  logic [15:0]   tm_rdata;

  srarq_ram #(.WIDTH(65), .DEPTH(WINDOW)) u_send_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata({cur.end_mark, cur.payload}),
    .re(st_re), .raddr(scan_slot), .rdata(st_rdata)
  );

  srarq_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_send_timers (
    .clk(clk), .we(tm_we), .waddr(tm_waddr), .wdata(tick_count),
    .re(tm_re), .raddr(scan_slot), .rdata(tm_rdata)
  );

  srarq_ram #(.WIDTH(65), .DEPTH(WINDOW)) u_recv_store (
    .clk(clk), .we(rv_we), .waddr(rv_waddr), .wdata({cur.end_mark, cur.payload}),
    .re(rv_re), .raddr(rv_raddr), .rdata(rv_rdata)
  );

  // next slot for a sequence number; wraps to 0 after the last slot or when the number wraps
  function automatic logic [SW-1:0] slot_inc(input logic [15:0] seq,
                                             input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (seq == 16'hffff || s == LAST_SLOT) begin
      r = '0;
    end else begin
      r = s + SW'(1);
    end
    return r;
  endfunction

  logic [15:0]   outstanding;
  logic [15:0]   d_recv, back_d, d_send;
  logic [SW-1:0] cur_slot;
  logic          win_full;
  logic          out_free, can_emit, emit, flush_go, out_load;
  logic          timed;
  logic          dlv_more;
  logic          scan_live;
  srarq_pkg::result_t res;

  always_comb begin
    outstanding = next_send_seq - tx_base;
    d_recv      = cur.rx_seq - rx_base;
    back_d      = rx_base - cur.rx_seq;
    d_send      = cur.rx_seq - tx_base;
    cur_slot    = cur.rx_slot[SW-1:0];
    win_full    = (outstanding >= WIN16);
    out_free    = !out_valid || !out_stall;
    can_emit    = !pend_valid || out_free;
    timed       = ((tick_count - tm_rdata) >= timeout_ticks);
    dlv_more    = (dcount != WINC) && recv_valid[rb_slot];
    scan_live   = (remain != '0) && flag_out[scan_slot] && !flag_ack[scan_slot];
  end

  // result produced in the current state
  always_comb begin
    emit     = 1'b0;
    flush_go = 1'b0;
    res      = '0;
    case (state)
      B_SEND: begin
        emit = can_emit;
        if (win_full) begin
          res.kind = srarq_pkg::KIND_FULL;
          res.seq  = next_send_seq;
        end else begin
          res.kind    = srarq_pkg::KIND_DATA;
          res.seq     = next_send_seq;
          res.check   = cur.csum;
          res.data    = cur.payload;
          res.msg_end = cur.end_mark;
        end
      end
      B_RXD, B_RXOLD: begin
        emit      = can_emit;
        res.kind  = srarq_pkg::KIND_ACK;
        res.seq   = cur.rx_seq;
        res.check = srarq_pkg::ACK_CHECK;
        res.data  = srarq_pkg::ACK_DATA;
      end
      B_DLV_EMIT: begin
        emit        = can_emit;
        res.kind    = srarq_pkg::KIND_CHUNK;
        res.seq     = rx_base;
        res.data    = rv_rdata[63:0];
        res.msg_end = rv_rdata[64];
      end
      B_TICK_EV: begin
        emit        = timed && can_emit;
        res.kind    = srarq_pkg::KIND_DATA;
        res.seq     = scan_q;
        res.check   = srarq_pkg::csum(st_rdata[63:0]);
        res.data    = st_rdata[63:0];
        res.msg_end = st_rdata[64];
      end
      B_FLUSH: begin
        flush_go = pend_valid && out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    out_load = (emit && pend_valid) || flush_go;
  end

  // memory control
  always_comb begin
    st_we    = (state == B_SEND) && can_emit && !win_full;
    st_waddr = ns_slot;
    tm_we    = st_we || ((state == B_TICK_EV) && emit);
    tm_waddr = (state == B_SEND) ? ns_slot : scan_slot;
    st_re    = (state == B_TICK_RD) && scan_live;
    tm_re    = st_re;
    rv_we    = (state == B_RXD) && can_emit;
    rv_waddr = cur_slot;
    rv_re    = (state == B_DLV_CHK) && dlv_more;
    rv_raddr = rb_slot;
  end

  assign pop = (state == B_IDLE) && not_empty;

  // output register and pending result; last is set once the item is done
  always_ff @(posedge clk) begin
    if (emit) begin
      pend <= res;
    end
    if (out_load) begin
      out_item      <= pend;
      out_item.last <= flush_go;
    end
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        pend_valid <= 1'b1;
      end else if (flush_go) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      tx_base       <= '0;
      next_send_seq <= '0;
      rx_base       <= '0;
      tick_count    <= '0;
      sb_slot       <= '0;
      ns_slot       <= '0;
      rb_slot       <= '0;
      flag_out      <= '0;
      flag_ack      <= '0;
      recv_valid    <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (not_empty) begin
            cur   <= head;
            state <= B_DISPATCH;
          end
        end
        B_DISPATCH: begin
          case (cur.op)
            srarq_pkg::OP_SEND: state <= B_SEND;
            srarq_pkg::OP_RX: begin
              if (!cur.csum_ok) begin
                state <= B_IDLE;
              end else if (!cur.rx_is_ack) begin
                if (d_recv < WIN16) begin
                  state <= B_RXD;
                end else if (back_d >= 16'd1 && back_d <= WIN16) begin
                  state <= B_RXOLD;
                end else begin
                  state <= B_IDLE;
                end
              end else if (d_send < outstanding) begin
                flag_ack[cur_slot] <= 1'b1;
                state <= B_SLIDE;
              end else begin
                state <= B_IDLE;
              end
            end
            srarq_pkg::OP_TICK: begin
              tick_count <= tick_count + 16'd1;
              scan_q     <= tx_base;
              scan_slot  <= sb_slot;
              remain     <= CW'(outstanding);
              state      <= B_TICK_RD;
            end
            default: state <= B_IDLE;
          endcase
        end
        B_SEND: begin
          if (can_emit) begin
            if (!win_full) begin
              flag_out[ns_slot] <= 1'b1;
              flag_ack[ns_slot] <= 1'b0;
              next_send_seq     <= next_send_seq + 16'd1;
              ns_slot           <= slot_inc(next_send_seq, ns_slot);
            end
            state <= B_FLUSH;
          end
        end
        B_RXD: begin
          if (can_emit) begin
            recv_valid[cur_slot] <= 1'b1;
            dcount <= '0;
            state  <= B_DLV_CHK;
          end
        end
        B_RXOLD: begin
          if (can_emit) begin
            state <= B_FLUSH;
          end
        end
        B_DLV_CHK: begin
          state <= dlv_more ? B_DLV_EMIT : B_FLUSH;
        end
        B_DLV_EMIT: begin
          if (can_emit) begin
            recv_valid[rb_slot] <= 1'b0;
            rx_base   <= rx_base + 16'd1;
            rb_slot   <= slot_inc(rx_base, rb_slot);
            dcount    <= dcount + CW'(1);
            state     <= B_DLV_CHK;
          end
        end
        B_SLIDE: begin
          if (outstanding == 16'd0 || !flag_ack[sb_slot]) begin
            state <= B_IDLE;
          end else begin
            flag_out[sb_slot] <= 1'b0;
            flag_ack[sb_slot] <= 1'b0;
            tx_base   <= tx_base + 16'd1;
            sb_slot   <= slot_inc(tx_base, sb_slot);
          end
        end
        B_TICK_RD: begin
          if (remain == '0) begin
            state <= B_FLUSH;
          end else if (scan_live) begin
            state <= B_TICK_EV;
          end else begin
            scan_q    <= scan_q + 16'd1;
            scan_slot <= slot_inc(scan_q, scan_slot);
            remain    <= remain - CW'(1);
          end
        end
        B_TICK_EV: begin
          if (!timed || can_emit) begin
            scan_q    <= scan_q + 16'd1;
            scan_slot <= slot_inc(scan_q, scan_slot);
            remain    <= remain - CW'(1);
            state     <= B_TICK_RD;
          end
        end
        B_FLUSH: begin
          if (!pend_valid || out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/selective_repeat_arq_endpoint.sv
// flow: the front accepts an item, computes its checksum and slot (F_CALC) and pushes
//   it into the queue (F_PUSH); the back pops it, dispatches it, emits each result into
//   a pending register, and a final flush loads the last one into the output register
// the front takes a new item once the last one is pushed, while the back is still busy;
//   delivered chunks, tick scans, ack slides and output stalls all lengthen an item
// reset: synchronous rst clears window counters, flags and the queue; timeout_ticks = 3
`default_nettype none
module selective_repeat_arq_endpoint #(
  parameter int WINDOW = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire srarq_pkg::item_in_t in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output srarq_pkg::result_t       out_item,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [15:0]      timeout_ticks;
  logic             push, q_full, pop, not_empty;
  srarq_pkg::qent_t push_ent, head;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == srarq_pkg::REG_TIMEOUT) ? {16'd0, timeout_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= srarq_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == srarq_pkg::REG_TIMEOUT) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  srarq_front #(.WINDOW(WINDOW)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .push(push), .push_ent(push_ent), .q_full(q_full)
  );

  srarq_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_ent(push_ent), .full(q_full),
    .pop(pop), .head(head), .not_empty(not_empty)
  );

  srarq_back #(.WINDOW(WINDOW)) u_back (
    .clk(clk), .rst(rst), .timeout_ticks(timeout_ticks), .head(head),
    .not_empty(not_empty), .pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

endmodule
`default_nettype wire
